// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the depth-first walk block.
// Depends on signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked out of reset.
`define GDFW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Same-cycle implication, checked out of reset.
`define GDFW_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define GDFW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gdfw_pkg.sv =====
// Package for the depth-first walk block: sizes, function codes, microcode types
// and the microcode ROM. No dependencies.
`default_nettype none

package gdfw_pkg;

   localparam int VERTEX_W     = 4;
   localparam int MAX_VERTICES = 1 << VERTEX_W;
   localparam int COUNT_W      = VERTEX_W + 1;
   localparam int FUNC_W       = 2;
   localparam int CSR_W        = 5;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR    = 2'd0,
      FUNC_ADD_EDGE = 2'd1,
      FUNC_WALK     = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      STEP_IDLE    = 3'd0,
      STEP_DECODE  = 3'd1,
      STEP_START   = 3'd2,
      STEP_SCAN    = 3'd3,
      STEP_RESOLVE = 3'd4,
      STEP_FOUND   = 3'd5,
      STEP_POP     = 3'd6,
      STEP_FINISH  = 3'd7
   } step_type;

   typedef enum logic [2:0] {
      OP_NOP    = 3'd0,
      OP_LATCH  = 3'd1,
      OP_EDGE   = 3'd2,
      OP_START  = 3'd3,
      OP_SCAN   = 3'd4,
      OP_FOUND  = 3'd5,
      OP_POP    = 3'd6,
      OP_FINISH = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_REQ      = 3'd1,
      COND_WALK     = 3'd2,
      COND_START_OK = 3'd3,
      COND_DONE     = 3'd4,
      COND_HIT      = 3'd5,
      COND_EMPTY    = 3'd6
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      logic     accept;
      logic     wait_out;
      step_type jump_t;
      step_type jump_f;
   } ucode_type;

   // One control word per step: the op runs, then the condition picks the next step.
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, accept: 1'b0, wait_out: 1'b0,
            jump_t: STEP_IDLE, jump_f: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            w.op = OP_LATCH; w.cond = COND_REQ; w.accept = 1'b1;
            w.jump_t = STEP_DECODE; w.jump_f = STEP_IDLE;
         end
         STEP_DECODE: begin
            w.op = OP_EDGE; w.cond = COND_WALK;
            w.jump_t = STEP_START; w.jump_f = STEP_IDLE;
         end
         STEP_START: begin
            w.op = OP_START; w.cond = COND_START_OK;
            w.jump_t = STEP_SCAN; w.jump_f = STEP_IDLE;
         end
         STEP_SCAN: begin
            w.op = OP_SCAN; w.cond = COND_DONE;
            w.jump_t = STEP_RESOLVE; w.jump_f = STEP_SCAN;
         end
         STEP_RESOLVE: begin
            w.op = OP_NOP; w.cond = COND_HIT;
            w.jump_t = STEP_FOUND; w.jump_f = STEP_POP;
         end
         STEP_FOUND: begin
            w.op = OP_FOUND; w.cond = COND_ALWAYS; w.wait_out = 1'b1;
            w.jump_t = STEP_SCAN; w.jump_f = STEP_SCAN;
         end
         STEP_POP: begin
            w.op = OP_POP; w.cond = COND_EMPTY;
            w.jump_t = STEP_FINISH; w.jump_f = STEP_SCAN;
         end
         STEP_FINISH: begin
            w.op = OP_FINISH; w.cond = COND_ALWAYS; w.wait_out = 1'b1;
            w.jump_t = STEP_IDLE; w.jump_f = STEP_IDLE;
         end
         default: begin
            w.op = OP_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/graph_depth_first_walk.sv =====
// Clear and add-edge pass through the latch and decode steps only. A walk then starts,
// scans the row of the vertex on top of the stack one bit per cycle, pushes each hit
// and pops when the row is done; a start out of range ends the walk at the start step.
// One item at a time: a new beat is taken only once the previous walk ends.
// Reset (synchronous, active high) clears the edges, the visited map, the stack depth
// and the output valid, and sets the vertex count to 16; there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module graph_depth_first_walk
   import gdfw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // func[1:0], from_vertex[5:2], to_vertex[9:6]
   // Result channel.
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // vertex[3:0]
   output      logic                  rsp_tlast,   // last vertex of the walk
   // Vertex count register write.
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_W-1:0]      csr_data
);

   // Sequencer and control state.
   step_type                 upc_ff, upc_in;
   logic [CSR_W-1:0]         count_ff, count_in;
   logic [MAX_VERTICES-1:0]  adj_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]  adj_in [MAX_VERTICES];
   logic [MAX_VERTICES-1:0]  visited_ff, visited_in;
   logic [COUNT_W-1:0]       depth_ff, depth_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Datapath payload registers.
   logic [FUNC_W-1:0]        func_ff, func_in;
   logic [VERTEX_W-1:0]      from_ff, from_in;
   logic [VERTEX_W-1:0]      to_ff, to_in;
   logic [VERTEX_W-1:0]      cur_ff, cur_in;
   logic [COUNT_W-1:0]       scan_ff, scan_in;
   logic [VERTEX_W-1:0]      pend_ff, pend_in;
   logic [VERTEX_W-1:0]      rsp_vertex_ff, rsp_vertex_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Walk stack: each frame keeps its vertex and the next neighbor to try.
   logic [VERTEX_W-1:0]      stack_node_ff [MAX_VERTICES];
   logic [VERTEX_W-1:0]      stack_node_in [MAX_VERTICES];
   logic [COUNT_W-1:0]       stack_next_ff [MAX_VERTICES];
   logic [COUNT_W-1:0]       stack_next_in [MAX_VERTICES];

   ucode_type                uw;
   logic                     out_free;
   logic                     stall;
   logic                     cond_true;
   logic [COUNT_W-1:0]       cnt_eff;
   logic [MAX_VERTICES-1:0]  row;
   logic [VERTEX_W-1:0]      scan_idx;
   logic                     scan_in_range;
   logic                     hit;
   logic                     start_ok;
   logic                     depth_full;
   logic [VERTEX_W-1:0]      top_idx;
   logic [VERTEX_W-1:0]      parent_idx;
   logic [VERTEX_W-1:0]      push_idx;

   // A count above the vertex limit is used as the limit.
   assign cnt_eff = (count_ff > CSR_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                      : COUNT_W'(count_ff);

   // The row of the vertex on top of the stack is scanned one bit per cycle.
   assign row           = adj_ff[cur_ff];
   assign scan_idx      = scan_ff[VERTEX_W-1:0];
   assign scan_in_range = scan_ff < cnt_eff;
   assign hit           = scan_in_range && row[scan_idx] && !visited_ff[scan_idx];
   assign start_ok      = COUNT_W'(from_ff) < cnt_eff;
   assign depth_full    = depth_ff == COUNT_W'(MAX_VERTICES);
   assign top_idx       = VERTEX_W'(depth_ff - COUNT_W'(1));
   assign parent_idx    = VERTEX_W'(depth_ff - COUNT_W'(2));
   assign push_idx      = VERTEX_W'(depth_ff);

   // The output register frees up when empty or when its beat is taken this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Fetch the control word; output-producing steps hold while the result is blocked.
   assign uw    = ucode_rom(upc_ff);
   assign stall = uw.wait_out && !out_free;

   assign req_tready = uw.accept;
   assign csr_ready  = uw.accept;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_vertex_ff);
   assign rsp_tlast  = rsp_last_ff;

   // Condition select and step counter update.
   always_comb begin
      unique case (uw.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_REQ:      cond_true = req_tvalid;
         COND_WALK:     cond_true = func_ff == FUNC_WALK;
         COND_START_OK: cond_true = start_ok;
         COND_DONE:     cond_true = hit || !scan_in_range;
         COND_HIT:      cond_true = hit;
         COND_EMPTY:    cond_true = depth_ff == COUNT_W'(1);
         default:       cond_true = 1'b0;
      endcase
      if (stall) begin
         upc_in = upc_ff;
      end else if (cond_true) begin
         upc_in = uw.jump_t;
      end else begin
         upc_in = uw.jump_f;
      end
   end

   // Datapath driven by the op field of the current control word.
   always_comb begin
      count_in      = count_ff;
      adj_in        = adj_ff;
      visited_in    = visited_ff;
      depth_in      = depth_ff;
      func_in       = func_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      cur_in        = cur_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      stack_node_in = stack_node_ff;
      stack_next_in = stack_next_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end

      if (!stall) begin
         unique case (uw.op)
            OP_NOP: begin
            end
            OP_LATCH: begin
               if (req_tvalid) begin
                  func_in = req_tdata[FUNC_W-1:0];
                  from_in = req_tdata[FUNC_W +: VERTEX_W];
                  to_in   = req_tdata[FUNC_W + VERTEX_W +: VERTEX_W];
               end
            end
            OP_EDGE: begin
               if (func_ff == FUNC_CLEAR) begin
                  for (int r = 0; r < MAX_VERTICES; r++) begin
                     adj_in[r] = '0;
                  end
               end else if (func_ff == FUNC_ADD_EDGE) begin
                  adj_in[from_ff][to_ff] = 1'b1;
               end
            end
            OP_START: begin
               visited_in = '0;
               depth_in   = '0;
               if (start_ok) begin
                  visited_in[from_ff] = 1'b1;
                  pend_in             = from_ff;
                  stack_node_in[0]    = from_ff;
                  stack_next_in[0]    = '0;
                  depth_in            = COUNT_W'(1);
                  cur_in              = from_ff;
                  scan_in             = '0;
               end
            end
            OP_SCAN: begin
               if (!hit && scan_in_range) begin
                  scan_in = scan_ff + COUNT_W'(1);
               end
            end
            OP_FOUND: begin
               // The held vertex is not the last one, since another follows it.
               rsp_valid_in           = 1'b1;
               rsp_vertex_in          = pend_ff;
               rsp_last_in            = 1'b0;
               pend_in                = scan_idx;
               visited_in[scan_idx]   = 1'b1;
               stack_next_in[top_idx] = scan_ff + COUNT_W'(1);
               if (!depth_full) begin
                  stack_node_in[push_idx] = scan_idx;
                  stack_next_in[push_idx] = '0;
                  depth_in                = depth_ff + COUNT_W'(1);
                  cur_in                  = scan_idx;
                  scan_in                 = '0;
               end else begin
                  scan_in = scan_ff + COUNT_W'(1);
               end
            end
            OP_POP: begin
               depth_in = depth_ff - COUNT_W'(1);
               if (depth_ff != COUNT_W'(1)) begin
                  cur_in  = stack_node_ff[parent_idx];
                  scan_in = stack_next_ff[parent_idx];
               end
            end
            OP_FINISH: begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = pend_ff;
               rsp_last_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= STEP_IDLE;
         count_ff     <= CSR_W'(MAX_VERTICES);
         visited_ff   <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < MAX_VERTICES; r++) begin
            adj_ff[r] <= '0;
         end
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         adj_ff       <= adj_in;
      end
   end

   // Payload registers and the walk stack need no reset.
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      from_ff       <= from_in;
      to_ff         <= to_in;
      cur_ff        <= cur_in;
      scan_ff       <= scan_in;
      pend_ff       <= pend_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      stack_node_ff <= stack_node_in;
      stack_next_ff <= stack_next_in;
   end

   // The stack never grows past one frame per vertex.
   `GDFW_ASSERT(a_depth_bound, depth_ff <= COUNT_W'(MAX_VERTICES), "stack depth overflow")
   // A new request is only taken with an empty stack.
   `GDFW_ASSERT_IMP(a_idle_empty, req_tready, depth_ff == '0, "request taken mid-walk")
   // The closing step always leaves a flagged final vertex in the output register.
   `GDFW_ASSERT_NEXT(a_finish_last, (upc_ff == STEP_FINISH) && out_free,
                     rsp_tvalid && rsp_tlast, "final vertex not flagged")

endmodule

`default_nettype wire

// ===== tb/walk_order_checker.sv =====
// Checker for the depth-first walk block: mirrors the edge matrix and vertex count,
// predicts the preorder of every walk and compares each result beat with it.
// Depends on gdfw_pkg for sizes and function codes.
`default_nettype none

module walk_order_checker
   import gdfw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // func[1:0], from_vertex[5:2], to_vertex[9:6]
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,   // vertex[3:0]
   input  wire logic                  rsp_tlast,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [CSR_W-1:0]      csr_data,
   output int                         mismatch_count,
   output int                         results_pending
);

   localparam int COUNT_AT_RESET = 16;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                last_flag;
   } visit_type;

   logic [MAX_VERTICES-1:0] edge_rows [MAX_VERTICES];
   logic [CSR_W-1:0]        vertex_count;
   visit_type               visit_queue [$];
   int                      fail_total = 0;
   int                      pending_total = 0;

   assign mismatch_count  = fail_total;
   assign results_pending = pending_total;

   function automatic int count_in_use();
      return (int'(vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
   endfunction

   // Preorder, neighbors tried lowest index first. A stack of (vertex, next neighbor)
   // frames takes the place of recursion, bounded at MAX_VERTICES frames.
   function automatic void predict_walk(input logic [VERTEX_W-1:0] start);
      logic [MAX_VERTICES-1:0] seen;
      int        frame_node [MAX_VERTICES];
      int        frame_next [MAX_VERTICES];
      int        order [MAX_VERTICES];
      int        depth;
      int        produced;
      int        limit;
      int        probe;
      int        k;
      bit        hit;
      visit_type item;
      seen     = '0;
      produced = 0;
      limit    = count_in_use();
      if (int'(start) >= limit) begin
         return;
      end
      seen[start]   = 1'b1;
      order[0]      = int'(start);
      produced      = 1;
      frame_node[0] = int'(start);
      frame_next[0] = 0;
      depth         = 1;
      while (depth > 0) begin
         probe = frame_next[depth-1];
         hit   = 1'b0;
         while (probe < limit && !hit) begin
            if (edge_rows[frame_node[depth-1]][probe] && !seen[probe]) begin
               hit = 1'b1;
            end else begin
               probe++;
            end
         end
         if (hit) begin
            frame_next[depth-1] = probe + 1;
            seen[probe]         = 1'b1;
            order[produced]     = probe;
            produced++;
            if (depth < MAX_VERTICES) begin
               frame_node[depth] = probe;
               frame_next[depth] = 0;
               depth++;
            end
         end else begin
            depth--;
         end
      end
      for (k = 0; k < produced; k++) begin
         item.vertex    = VERTEX_W'(order[k]);
         item.last_flag = (k == produced - 1);
         visit_queue.push_back(item);
      end
   endfunction

   always @(posedge clock) begin : watch
      logic [FUNC_W-1:0]   func_bits;
      logic [VERTEX_W-1:0] from_vertex;
      logic [VERTEX_W-1:0] to_vertex;
      visit_type           want;
      if (reset) begin
         for (int r = 0; r < MAX_VERTICES; r++) begin
            edge_rows[r] = '0;
         end
         vertex_count = CSR_W'(COUNT_AT_RESET);
         visit_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            vertex_count = csr_data;
         end
         if (req_tvalid && req_tready) begin
            func_bits   = req_tdata[1:0];
            from_vertex = req_tdata[5:2];
            to_vertex   = req_tdata[9:6];
            case (func_bits)
               FUNC_CLEAR: begin
                  for (int r = 0; r < MAX_VERTICES; r++) begin
                     edge_rows[r] = '0;
                  end
               end
               FUNC_ADD_EDGE: begin
                  edge_rows[from_vertex][to_vertex] = 1'b1;
               end
               FUNC_WALK: begin
                  predict_walk(from_vertex);
               end
               default: begin
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (visit_queue.size() == 0) begin
               $error("unexpected result beat: vertex %0d last %0b",
                      rsp_tdata[VERTEX_W-1:0], rsp_tlast);
               fail_total++;
            end else begin
               want = visit_queue.pop_front();
               if (rsp_tdata[VERTEX_W-1:0] !== want.vertex) begin
                  $error("vertex: expected %0d, actual %0d", want.vertex,
                         rsp_tdata[VERTEX_W-1:0]);
                  fail_total++;
               end
               if (rsp_tlast !== want.last_flag) begin
                  $error("last: expected %0b, actual %0b", want.last_flag, rsp_tlast);
                  fail_total++;
               end
            end
         end
      end
      pending_total = visit_queue.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb_graph_depth_first_walk.sv =====
// Top of the depth-first walk testbench: clock, reset, request and vertex count
// stimulus, a randomly stalling result sink and the verdict.
// Depends on gdfw_pkg, graph_depth_first_walk and walk_order_checker.
`default_nettype none

module tb_graph_depth_first_walk
   import gdfw_pkg::*;
;

   // The slowest walk scans every row bit by bit; WALK_CYCLES is sized for it at the full
   // count. SETTLE_CYCLES is let pass before a register write and before the verdict, since
   // a clear, an add or an empty walk can still be in flight when nothing is pending.
   localparam int WALK_CYCLES   = MAX_VERTICES * MAX_VERTICES + 5 * MAX_VERTICES + 2;
   localparam int SETTLE_CYCLES = 2 * WALK_CYCLES;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASE_ITEMS   = 9;
   // The one function code the block does not define; it must change nothing.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;     // func[1:0], from_vertex[5:2], to_vertex[9:6]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;           // vertex[3:0]
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_W-1:0]      csr_data   = '0;

   int mismatch_count;
   int results_pending;
   int cycle_count = 0;
   // When set, neither side idles between beats.
   logic no_idle = 1'b0;
   // Vertices in use as last programmed; steers random vertices into range.
   int span = MAX_VERTICES;

   always #1 clock = ~clock;

   graph_depth_first_walk dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   walk_order_checker walk_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // Result sink. Before each beat it may drop tready for a random stall (none when no_idle
   // is set), then keeps it high until a beat is taken, so stalls land on every phase of a walk.
   initial begin : result_sink
      int stall;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Sends one request beat after a random gap. With no gap, tvalid simply stays high
   // so it is never lowered and raised again in the same time step.
   task automatic issue(input logic [FUNC_W-1:0] func, input logic [VERTEX_W-1:0] from_v,
                        input logic [VERTEX_W-1:0] to_v);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, to_v, from_v, func};
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds off the sender until every predicted vertex has arrived, then lets the
   // block finish any item that produces no result.
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Rewrites the vertex count; only ever done with the block idle.
   task automatic program_count(input int value);
      drain_and_settle();
      csr_valid <= 1'b1;
      csr_data  <= CSR_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      span = (value > MAX_VERTICES) ? MAX_VERTICES : value;
   endtask

   // A vertex that is in use, or any vertex when none is.
   function automatic logic [VERTEX_W-1:0] pick_vertex();
      if (span > 0) begin
         return VERTEX_W'($urandom_range(0, span - 1));
      end
      return VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
   endfunction

   function automatic logic [VERTEX_W-1:0] any_vertex();
      return VERTEX_W'($urandom_range(0, MAX_VERTICES - 1));
   endfunction

   initial begin : stimulus
      int count_plan [11];
      int perm [MAX_VERTICES];
      int phase;
      int sent;
      int roll;
      int burst;
      int swap_at;
      int hold;
      int k;

      count_plan = '{16, 1, 2, 31, 8, 17, 0, 16, 0, 5, 16};
      count_plan[8] = $urandom_range(1, MAX_VERTICES);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset count of 16.
      // Empty graph: a walk gives only its start, at both ends of the range.
      issue(FUNC_WALK, 4'd0, 4'd0);
      issue(FUNC_WALK, 4'd15, 4'd15);
      // A small graph with a cycle, a self loop and the top vertex.
      issue(FUNC_ADD_EDGE, 4'd0, 4'd15);
      issue(FUNC_ADD_EDGE, 4'd0, 4'd1);
      issue(FUNC_ADD_EDGE, 4'd1, 4'd1);
      issue(FUNC_ADD_EDGE, 4'd1, 4'd2);
      issue(FUNC_ADD_EDGE, 4'd2, 4'd0);
      issue(FUNC_ADD_EDGE, 4'd15, 4'd3);
      issue(FUNC_WALK, 4'd0, 4'd0);
      // The unused code must leave the matrix alone.
      issue(FUNC_UNUSED, 4'd15, 4'd15);
      issue(FUNC_WALK, 4'd2, 4'd9);
      // Clear ignores its vertex fields.
      issue(FUNC_CLEAR, 4'd15, 4'd15);
      issue(FUNC_WALK, 4'd0, 4'd0);
      // No vertex in use: no walk gives anything.
      program_count(0);
      issue(FUNC_WALK, 4'd0, 4'd0);
      // A count above the matrix size acts as the full size.
      program_count(31);
      issue(FUNC_ADD_EDGE, 4'd15, 4'd14);
      issue(FUNC_WALK, 4'd15, 4'd0);
      // Edges beyond the count are kept but not followed; a start beyond it is empty.
      program_count(3);
      issue(FUNC_ADD_EDGE, 4'd0, 4'd5);
      issue(FUNC_ADD_EDGE, 4'd5, 4'd1);
      issue(FUNC_ADD_EDGE, 4'd0, 4'd2);
      issue(FUNC_WALK, 4'd0, 4'd0);
      issue(FUNC_WALK, 4'd5, 4'd0);
      issue(FUNC_WALK, 4'd2, 4'd0);
      program_count(1);
      issue(FUNC_WALK, 4'd0, 4'd0);
      issue(FUNC_WALK, 4'd1, 4'd0);

      // Random part: one phase per count setting. Each phase builds graphs and walks
      // them; half the sequences are edges in range followed by a walk, the rest are
      // long chains for a deep stack, dense bursts, clears and raw noise.
      for (phase = 0; phase < 11; phase++) begin
         program_count(count_plan[phase]);
         no_idle <= (phase % 4 == 2);
         if ($urandom_range(0, 1) == 1) begin
            issue(FUNC_CLEAR, any_vertex(), any_vertex());
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            roll = $urandom_range(0, 9);
            if (roll <= 4) begin
               burst = $urandom_range(1, 4);
               repeat (burst) issue(FUNC_ADD_EDGE, pick_vertex(), pick_vertex());
               issue(FUNC_WALK, pick_vertex(), any_vertex());
               sent += burst + 1;
            end else if (roll == 5) begin
               // A path through every vertex in use in shuffled order.
               for (k = 0; k < MAX_VERTICES; k++) begin
                  perm[k] = k;
               end
               for (k = span - 1; k > 0; k--) begin
                  swap_at       = $urandom_range(0, k);
                  hold          = perm[k];
                  perm[k]       = perm[swap_at];
                  perm[swap_at] = hold;
               end
               issue(FUNC_CLEAR, any_vertex(), any_vertex());
               for (k = 0; k < span - 1; k++) begin
                  issue(FUNC_ADD_EDGE, VERTEX_W'(perm[k]), VERTEX_W'(perm[k+1]));
               end
               issue(FUNC_WALK, VERTEX_W'(perm[0]), any_vertex());
               sent += span + 1;
            end else if (roll == 6) begin
               burst = $urandom_range(6, 12);
               repeat (burst) issue(FUNC_ADD_EDGE, pick_vertex(), pick_vertex());
               issue(FUNC_WALK, pick_vertex(), any_vertex());
               sent += burst + 1;
            end else if (roll == 7) begin
               issue(FUNC_W'($urandom_range(0, 3)), any_vertex(), any_vertex());
               sent++;
            end else if (roll == 8) begin
               issue(FUNC_CLEAR, any_vertex(), any_vertex());
               issue(FUNC_WALK, pick_vertex(), any_vertex());
               sent += 2;
            end else begin
               // Any start, in range or not, on edges that may reach past the count.
               issue(FUNC_ADD_EDGE, any_vertex(), any_vertex());
               issue(FUNC_WALK, any_vertex(), any_vertex());
               sent += 2;
            end
         end
      end

      drain_and_settle();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/gdfw_pkg.sv
rtl/graph_depth_first_walk.sv
tb/walk_order_checker.sv
tb/tb_graph_depth_first_walk.sv
